[src/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, constants and helpers of the set-associative LRU tag block.
// ----------------------------------------------------------------------------
package salc_pkg;

   // Built geometry
   localparam int MAX_SETS = 256;
   localparam int MAX_WAYS = 8;
   localparam int SET_W    = $clog2(MAX_SETS);
   localparam int WAY_W    = $clog2(MAX_WAYS);
   localparam int IDX_CAP  = SET_W;              // largest usable index width
   localparam int IW_W     = $clog2(IDX_CAP + 1);

   // Field widths
   localparam int ADDR_W   = 64;
   localparam int TAG_W    = 64;
   localparam int LCB_W    = 5;
   localparam int LW_W     = 2;
   localparam int LBB_W    = 4;

   // Configuration register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_LOG_CACHE_BYTES = 2'd0,
      REG_LOG_WAYS        = 2'd1,
      REG_LOG_BLOCK_BYTES = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [LCB_W-1:0] log_cache_bytes;
      logic [LW_W-1:0]  log_ways;
      logic [LBB_W-1:0] log_block_bytes;
   } cfg_type;

   // One set: all ways side by side
   typedef struct packed {
      logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
      logic [MAX_WAYS-1:0][WAY_W-1:0] ranks;
      logic [MAX_WAYS-1:0]            valid;
      logic [MAX_WAYS-1:0]            dirty;
   } row_type;

   // Outcome of the way scan
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic             found;     // an invalid way exists
      logic [WAY_W-1:0] inv_way;   // highest-numbered invalid way
      logic [WAY_W-1:0] lru_way;   // way with the highest rank
   } scan_type;

   // Row as a fresh cache holds it: nothing valid, rank equal to way number
   function automatic row_type clear_row();
      row_type r;
      r = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         r.ranks[w] = WAY_W'(w);
      end
      return r;
   endfunction

endpackage

[src/set_assoc_lru_cache_tags.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag and replacement side of a write-back, write-allocate set-associative
// cache with true LRU order.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one access per item: tuser is the kind (0 read, 1 write),
//   tdata the 64-bit byte address. rsp_* returns one item per access: hit,
//   the way that hit or was filled, and whether a dirty line was evicted.
//   Geometry comes from three registers on the csr_* port; write them only
//   while no access is in flight.
// Timing
//   The ways of a set are checked one per cycle by a single comparator, and
//   the block takes no new item until the result of the last one has been
//   moved to the output register.
// Reset and register writes
//   After reset, and after every write to a known register, the set store
//   is swept one set per cycle; req_tready stays low meanwhile.
// Stalls
//   A result waits in the output register while rsp_tready is low; a later
//   item is still accepted and its result is held back until the slot frees.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags (
   input  logic                               clock,
   input  logic                               reset,
   // access items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [63:0]                        req_tdata,   // [63:0] address
   input  logic [0:0]                         req_tuser,   // [0] action
   // result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [0] hit, [3:1] way_used,
                                                           // [4] write_back, [7:5] zero
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic                           action_ff, action_in;
   logic [salc_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [salc_pkg::SET_W-1:0]     set_ff, set_in;
   logic [salc_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic [salc_pkg::WAY_W-1:0]     way_cnt_ff, way_cnt_in;
   logic                           clr_active_ff, clr_active_in;
   logic [salc_pkg::SET_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                           res_hit_ff, res_hit_in;
   logic [salc_pkg::WAY_W-1:0]     res_way_ff, res_way_in;
   logic                           res_wb_ff, res_wb_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_data_ff, rsp_data_in;

   salc_pkg::cfg_type              cfg;
   logic                           clear_req;
   salc_pkg::row_type              rd_row;
   salc_pkg::row_type              new_row;
   salc_pkg::row_type              wr_row;
   logic                           wr_en;
   logic [salc_pkg::SET_W-1:0]     wr_addr;
   salc_pkg::scan_type             scan;

   logic [4:0]                     lw_plus_b;
   logic [4:0]                     iw_raw;
   logic [salc_pkg::IW_W-1:0]      iw;
   logic [salc_pkg::ADDR_W-1:0]    set_shift;
   logic [salc_pkg::SET_W-1:0]     set_mask;
   logic [salc_pkg::WAY_W-1:0]     way_last;
   logic [salc_pkg::WAY_W-1:0]     sel_way;
   logic [salc_pkg::WAY_W-1:0]     old_rank;
   logic                           sel_wb;
   logic                           req_accept;
   logic                           slot_free;

   salc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .clear_req   (clear_req)
   );

   salc_tag_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (set_ff),
      .rd_row  (rd_row)
   );

   salc_way_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_READ),
      .step   (state_ff == ST_SCAN),
      .way    (way_cnt_ff),
      .row    (rd_row),
      .tag    (tag_ff),
      .result (scan)
   );

   // Address split: index width from the geometry, capped at the built sets
   always_comb begin
      lw_plus_b = 5'(cfg.log_ways) + 5'(cfg.log_block_bytes);
      iw_raw    = (cfg.log_cache_bytes >= lw_plus_b) ? (cfg.log_cache_bytes - lw_plus_b)
                                                     : 5'd0;
      iw        = (iw_raw > 5'(salc_pkg::IDX_CAP)) ? salc_pkg::IW_W'(salc_pkg::IDX_CAP)
                                                   : iw_raw[salc_pkg::IW_W-1:0];
      set_shift = addr_ff >> cfg.log_block_bytes;
      set_mask  = ~({salc_pkg::SET_W{1'b1}} << iw);
      set_in    = set_shift[salc_pkg::SET_W-1:0] & set_mask;
      tag_in    = addr_ff >> (5'(cfg.log_block_bytes) + 5'(iw));
      way_last  = ~({salc_pkg::WAY_W{1'b1}} << cfg.log_ways);
   end

   // Victim choice and the updated row
   always_comb begin
      if (scan.hit) begin
         sel_way = scan.hit_way;
      end else if (scan.found) begin
         sel_way = scan.inv_way;
      end else begin
         sel_way = scan.lru_way;
      end
      sel_wb   = !scan.hit && !scan.found && rd_row.dirty[scan.lru_way];
      old_rank = rd_row.ranks[sel_way];
      new_row  = rd_row;
      for (int w = 0; w < salc_pkg::MAX_WAYS; w++) begin
         if (salc_pkg::WAY_W'(w) == sel_way) begin
            new_row.ranks[w] = '0;
         end else if (rd_row.ranks[w] < old_rank) begin
            new_row.ranks[w] = rd_row.ranks[w] + salc_pkg::WAY_W'(1);
         end
      end
      if (!scan.hit) begin
         new_row.tags[sel_way]  = tag_ff;
         new_row.valid[sel_way] = 1'b1;
         new_row.dirty[sel_way] = action_ff;
      end else if (action_ff) begin
         new_row.dirty[sel_way] = 1'b1;
      end
   end

   // Store write: clearing sweep or the update of one set
   always_comb begin
      wr_en   = clr_active_ff || (state_ff == ST_UPDATE);
      wr_addr = clr_active_ff ? clr_cnt_ff : set_ff;
      wr_row  = clr_active_ff ? salc_pkg::clear_row() : new_row;
   end

   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      addr_in       = addr_ff;
      way_cnt_in    = way_cnt_ff;
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      res_hit_in    = res_hit_ff;
      res_way_in    = res_way_ff;
      res_wb_in     = res_wb_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_tuser[0];
               addr_in   = req_tdata;
               state_in  = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            way_cnt_in = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (way_cnt_ff == way_last) begin
               state_in = ST_UPDATE;
            end else begin
               way_cnt_in = way_cnt_ff + salc_pkg::WAY_W'(1);
            end
         end
         ST_UPDATE: begin
            res_hit_in = scan.hit;
            res_way_in = sel_way;
            res_wb_in  = sel_wb;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_wb_ff, res_way_ff, res_hit_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Clearing sweep, restarted by a write to any known register
      if (clear_req) begin
         clr_active_in = 1'b1;
         clr_cnt_in    = '0;
      end else if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + salc_pkg::SET_W'(1);
         if (clr_cnt_ff == salc_pkg::SET_W'(salc_pkg::MAX_SETS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         way_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         way_cnt_ff    <= way_cnt_in;
      end
      action_ff   <= action_in;
      addr_ff     <= addr_in;
      set_ff      <= (state_ff == ST_ADDR) ? set_in : set_ff;
      tag_ff      <= (state_ff == ST_ADDR) ? tag_in : tag_ff;
      res_hit_ff  <= res_hit_in;
      res_way_ff  <= res_way_in;
      res_wb_ff   <= res_wb_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE) && !clr_active_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/salc_csr.sv]
// ----------------------------------------------------------------------------
// salc_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module salc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output salc_pkg::cfg_type                   cfg,
   output logic                                clear_req
);

   logic [salc_pkg::LCB_W-1:0] log_cache_bytes_ff, log_cache_bytes_in;
   logic [salc_pkg::LW_W-1:0]  log_ways_ff,        log_ways_in;
   logic [salc_pkg::LBB_W-1:0] log_block_bytes_ff, log_block_bytes_in;
   logic                       wr_strobe;
   logic [1:0]                 reg_sel;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   // Register writes; a write to a known register also restarts the clearing sweep
   always_comb begin
      log_cache_bytes_in = log_cache_bytes_ff;
      log_ways_in        = log_ways_ff;
      log_block_bytes_in = log_block_bytes_ff;
      clear_req          = 1'b0;
      if (wr_strobe) begin
         case (reg_sel)
            salc_pkg::REG_LOG_CACHE_BYTES: begin
               log_cache_bytes_in = csr_pwdata[salc_pkg::LCB_W-1:0];
               clear_req          = 1'b1;
            end
            salc_pkg::REG_LOG_WAYS: begin
               log_ways_in = csr_pwdata[salc_pkg::LW_W-1:0];
               clear_req   = 1'b1;
            end
            salc_pkg::REG_LOG_BLOCK_BYTES: begin
               log_block_bytes_in = csr_pwdata[salc_pkg::LBB_W-1:0];
               clear_req          = 1'b1;
            end
            default: begin
               clear_req = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_cache_bytes_ff <= salc_pkg::LCB_W'(12);
         log_ways_ff        <= salc_pkg::LW_W'(1);
         log_block_bytes_ff <= salc_pkg::LBB_W'(5);
      end else begin
         log_cache_bytes_ff <= log_cache_bytes_in;
         log_ways_ff        <= log_ways_in;
         log_block_bytes_ff <= log_block_bytes_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_sel)
         salc_pkg::REG_LOG_CACHE_BYTES:
            csr_prdata = salc_pkg::CSR_DATA_W'(log_cache_bytes_ff);
         salc_pkg::REG_LOG_WAYS:
            csr_prdata = salc_pkg::CSR_DATA_W'(log_ways_ff);
         salc_pkg::REG_LOG_BLOCK_BYTES:
            csr_prdata = salc_pkg::CSR_DATA_W'(log_block_bytes_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.log_cache_bytes = log_cache_bytes_ff;
   assign cfg.log_ways        = log_ways_ff;
   assign cfg.log_block_bytes = log_block_bytes_ff;

endmodule

[src/salc_tag_ram.sv]
// ----------------------------------------------------------------------------
// salc_tag_ram
// Set store: one row per set with tags, ranks, valid and dirty bits of all
// ways. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module salc_tag_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [salc_pkg::SET_W-1:0]   wr_addr,
   input  salc_pkg::row_type            wr_row,
   input  logic                         rd_en,
   input  logic [salc_pkg::SET_W-1:0]   rd_addr,
   output salc_pkg::row_type            rd_row
);

   salc_pkg::row_type mem [salc_pkg::MAX_SETS];
   salc_pkg::row_type rd_row_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

[src/salc_way_scan.sv]
// ----------------------------------------------------------------------------
// salc_way_scan
// Shared way comparator: looks at one way of the set per cycle and keeps
// the running hit, last invalid way and highest-rank way.
// ----------------------------------------------------------------------------
module salc_way_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         step,
   input  logic [salc_pkg::WAY_W-1:0]   way,
   input  salc_pkg::row_type            row,
   input  logic [salc_pkg::TAG_W-1:0]   tag,
   output salc_pkg::scan_type           result
);

   logic                       hit_ff,     hit_in;
   logic [salc_pkg::WAY_W-1:0] hit_way_ff, hit_way_in;
   logic                       found_ff,   found_in;
   logic [salc_pkg::WAY_W-1:0] inv_way_ff, inv_way_in;
   logic [salc_pkg::WAY_W-1:0] lru_way_ff, lru_way_in;
   logic [salc_pkg::WAY_W-1:0] best_ff,    best_in;
   logic                       cur_valid;
   logic [salc_pkg::WAY_W-1:0] cur_rank;
   logic                       tag_eq;

   assign cur_valid = row.valid[way];
   assign cur_rank  = row.ranks[way];
   assign tag_eq    = (row.tags[way] == tag);

   // One compare step
   always_comb begin
      hit_in     = hit_ff;
      hit_way_in = hit_way_ff;
      found_in   = found_ff;
      inv_way_in = inv_way_ff;
      lru_way_in = lru_way_ff;
      best_in    = best_ff;
      if (start) begin
         hit_in   = 1'b0;
         found_in = 1'b0;
         best_in  = '0;
      end else if (step) begin
         if (cur_valid && tag_eq) begin
            hit_in     = 1'b1;
            hit_way_in = way;
         end
         if (!cur_valid) begin
            found_in   = 1'b1;
            inv_way_in = way;
         end
         if (cur_rank >= best_ff) begin
            best_in    = cur_rank;
            lru_way_in = way;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
         best_ff  <= '0;
      end else begin
         hit_ff   <= hit_in;
         found_ff <= found_in;
         best_ff  <= best_in;
      end
      hit_way_ff <= hit_way_in;
      inv_way_ff <= inv_way_in;
      lru_way_ff <= lru_way_in;
   end

   assign result.hit     = hit_ff;
   assign result.hit_way = hit_way_ff;
   assign result.found   = found_ff;
   assign result.inv_way = inv_way_ff;
   assign result.lru_way = lru_way_ff;

endmodule

[src/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the LRU tag block, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [7:0]                       rsp_tdata,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [salc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic                             csr_pready
);

   // One item at a time: no new item right after one is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous one still in work");

   // A write-back only happens on a miss
   a_wb_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[4]))
      else $error("write-back reported on a hit");

   // A write to a known register starts the clearing sweep
   a_clear_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr[3:2] != 2'd3))
      |=> !req_tready)
      else $error("item accepted during clearing sweep");

   // Sweep after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("ready straight after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);

[sim/tb_set_assoc_lru_cache_tags.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags
// Self-checking bench for the LRU tag block. A scoreboard class predicts hit,
// way and write-back for every accepted access and checks each result item
// in order. The reset geometry and the next two begin with a few directed
// accesses; every geometry runs random ones that mostly come from a small
// pool of lines crowded into two sets. Sender bursts and receiver stalls
// are random, with one long receiver hold-off and one full drain mid-phase.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags;

   // Geometry as built
   localparam int SETS      = salc_pkg::MAX_SETS;
   localparam int WAYS      = salc_pkg::MAX_WAYS;
   localparam int INDEX_CAP = salc_pkg::IDX_CAP;   // largest k with 2^k <= SETS

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam int RANDOM_PER_PHASE = 56;
   localparam int SETTLE_CYCLES    = 20;
   localparam int HOLD_CYCLES      = 400;
   localparam int WATCHDOG_LIMIT   = 4000;

   // Geometries run after the reset one: log cache bytes, log ways, log block
   localparam int PHASES = 7;
   localparam int PLAN_LCB [PHASES] = '{24,  0, 10, 6, 13, 3, 12};
   localparam int PLAN_LW  [PHASES] = '{ 0,  3,  3, 2,  1, 3,  1};
   localparam int PLAN_LBB [PHASES] = '{ 0, 12,  4, 2,  6, 0,  5};

   typedef struct packed {
      logic       hit;
      logic [2:0] way;
      logic       write_back;
   } lookup_type;

   typedef enum int {RX_FLOW, RX_COIN, RX_THIRD, RX_SPARSE, RX_HOLD} rx_mode_type;

   // Predicts the tag block and checks its results in order
   class lru_tag_scoreboard;
      logic [4:0]  log_cache_bytes;
      logic [1:0]  log_ways;
      logic [3:0]  log_block_bytes;
      logic [63:0] tags  [SETS][WAYS];
      bit          valid [SETS][WAYS];
      bit          dirty [SETS][WAYS];
      int unsigned rank  [SETS][WAYS];
      lookup_type  lookups_due[$];
      int unsigned errors, checked, hits, dirty_evictions;

      function new();
         log_cache_bytes = 5'd12;
         log_ways        = 2'd1;
         log_block_bytes = 4'd5;
         errors = 0;
         checked = 0;
         hits = 0;
         dirty_evictions = 0;
         clear_lines();
      endfunction

      // Fresh cache: nothing valid, rank equal to way number
      function void clear_lines();
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               tags[s][w]  = '0;
               valid[s][w] = 1'b0;
               dirty[s][w] = 1'b0;
               rank[s][w]  = w;
            end
         end
      endfunction

      function void write_reg(input salc_pkg::reg_index_type idx,
                              input logic [31:0] value);
         case (idx)
            salc_pkg::REG_LOG_CACHE_BYTES: log_cache_bytes = value[4:0];
            salc_pkg::REG_LOG_WAYS:        log_ways        = value[1:0];
            salc_pkg::REG_LOG_BLOCK_BYTES: log_block_bytes = value[3:0];
            default: ;
         endcase
         clear_lines();
      endfunction

      function int unsigned index_width();
         int unsigned need, iw;
         need = log_ways + log_block_bytes;
         iw = (log_cache_bytes >= need) ? log_cache_bytes - need : 0;
         if (iw > INDEX_CAP) iw = INDEX_CAP;
         return iw;
      endfunction

      function int unsigned pending();
         return lookups_due.size();
      endfunction

      // Look up one access, update the set and queue the outcome
      function void note_access(input logic is_write, input logic [63:0] addr);
         int unsigned iw, ways, set_no, way, top, old;
         logic [63:0] tag;
         bit          found;
         lookup_type  r;
         iw     = index_width();
         ways   = 1 << log_ways;
         set_no = int'((addr >> log_block_bytes) & ((64'd1 << iw) - 64'd1));
         tag    = addr >> (log_block_bytes + iw);
         way    = 0;
         r      = '0;
         for (int w = 0; w < ways; w++) begin
            if (valid[set_no][w] && tags[set_no][w] == tag) begin
               r.hit = 1'b1;
               way   = w;
            end
         end
         if (r.hit) begin
            if (is_write) dirty[set_no][way] = 1'b1;
         end else begin
            // highest free way first, else the least recently used one
            found = 1'b0;
            for (int w = 0; w < ways; w++) begin
               if (!valid[set_no][w]) begin
                  way   = w;
                  found = 1'b1;
               end
            end
            if (!found) begin
               top = 0;
               for (int w = 0; w < ways; w++) begin
                  if (rank[set_no][w] >= top) begin
                     top = rank[set_no][w];
                     way = w;
                  end
               end
               r.write_back = dirty[set_no][way];
            end
            tags[set_no][way]  = tag;
            valid[set_no][way] = 1'b1;
            dirty[set_no][way] = is_write;
         end
         // touched way becomes most recent, newer ways age by one
         old = rank[set_no][way];
         for (int w = 0; w < WAYS; w++) begin
            if (w != way && rank[set_no][w] < old) rank[set_no][w]++;
         end
         rank[set_no][way] = 0;
         r.way = way[2:0];
         lookups_due.push_back(r);
      endfunction

      function void check_lookup(input logic [7:0] data);
         lookup_type e;
         if (lookups_due.size() == 0) begin
            $display("%0t ns: result item %h with no access outstanding", $time, data);
            errors++;
            return;
         end
         e = lookups_due.pop_front();
         checked++;
         if (e.hit) hits++;
         if (e.write_back) dirty_evictions++;
         if (data[0] !== e.hit) begin
            $display("%0t ns: hit expected %0d actual %0d", $time, e.hit, data[0]);
            errors++;
         end
         if (data[3:1] !== e.way) begin
            $display("%0t ns: way_used expected %0d actual %0d", $time, e.way, data[3:1]);
            errors++;
         end
         if (data[4] !== e.write_back) begin
            $display("%0t ns: write_back expected %0d actual %0d",
                     $time, e.write_back, data[4]);
            errors++;
         end
         if (data[7:5] !== 3'b000) begin
            $display("%0t ns: padding expected 0 actual %b", $time, data[7:5]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;      // [63:0] address
   logic [0:0]  req_tuser = '0;      // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [0] hit, [3:1] way_used, [4] write_back
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [salc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [salc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [salc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   lru_tag_scoreboard sb = new();

   int unsigned burst_left  = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_done  = 0;
   int unsigned quiet_cycles = 0;

   set_assoc_lru_cache_tags u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_access(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_lookup(rsp_tdata);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stall segments, plus the long hold-off when asked
   initial begin : rsp_pattern
      rx_mode_type mode;
      int unsigned span, tick;
      mode = RX_FLOW;
      span = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (span == 0) begin
            if (holds_done != holds_asked) begin
               holds_done++;
               mode = RX_HOLD;
               span = HOLD_CYCLES;
            end else begin
               mode = rx_mode_type'($urandom_range(0, 3));
               span = $urandom_range(8, 60);
            end
         end
         span--;
         tick++;
         case (mode)
            RX_FLOW:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_THIRD:  rsp_tready <= (tick % 3 == 0);
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= 1'b0;
         endcase
      end
   end

   // Offer one access and wait for it to be taken; bursts end in a gap
   task automatic send_access(input logic is_write, input logic [63:0] addr);
      int unsigned gap;
      req_tuser  <= is_write;
      req_tdata  <= addr;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Stop offering, wait for every result, then let the pipeline settle.
   // It first waits for the monitor to log the last accepted item.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup, then access, then idle
   task automatic csr_write(input salc_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= salc_pkg::CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a small pool of lines in two sets, with random offsets
   task automatic run_random(input int unsigned count, input int pause_at);
      logic [63:0] lines[$];
      logic [63:0] set_mask, off_mask, a;
      int unsigned iw, sh, n_lines;
      iw       = sb.index_width();
      sh       = sb.log_block_bytes;
      set_mask = ((64'd1 << iw) - 64'd1) << sh;
      off_mask = (64'd1 << sh) - 64'd1;
      n_lines  = 2 * (1 << sb.log_ways) + 2;
      repeat (n_lines) begin
         a = {$urandom(), $urandom()};
         a = (a & ~set_mask) | (($urandom_range(0, 1) != 0) ? set_mask : 64'd0);
         lines.push_back(a);
      end
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) wait_drained();
         if ($urandom_range(0, 9) < 8) begin
            a = lines[$urandom_range(0, n_lines - 1)];
            a = (a & ~off_mask) | ({$urandom(), $urandom()} & off_mask);
         end else begin
            a = {$urandom(), $urandom()};
         end
         send_access(1'($urandom_range(0, 1)), a);
      end
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: 4 KiB, two ways, 32-byte lines, 64 sets
      send_access(ACT_READ,  64'h0);                    // cold miss, highest free way
      send_access(ACT_WRITE, 64'h0);                    // write hit marks dirty
      send_access(ACT_READ,  64'hFFFF_FFFF_FFFF_FFFF);  // top set, all-ones tag
      send_access(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFE0);  // same line, other offset
      send_access(ACT_READ,  64'h800);                  // fills the other way of set 0
      send_access(ACT_READ,  64'h1000);                 // set full: dirty victim
      send_access(ACT_WRITE, 64'h800);                  // hit refreshes order
      send_access(ACT_READ,  64'h0);                    // clean victim
      send_access(ACT_READ,  64'h1000);                 // dirty victim again
      send_access(ACT_WRITE, 64'h8000_0000_0000_0000);  // top tag bit
      run_random(RANDOM_PER_PHASE, -1);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         csr_write(salc_pkg::REG_LOG_WAYS,        PLAN_LW[p]);
         csr_write(salc_pkg::REG_LOG_BLOCK_BYTES, PLAN_LBB[p]);
         csr_write(salc_pkg::REG_LOG_CACHE_BYTES, PLAN_LCB[p]);
         if (p == 0) begin
            // index width capped at the built set count, direct mapped
            send_access(ACT_READ,  64'h0);   // store was cleared by the writes
            send_access(ACT_WRITE, 64'h0);
            send_access(ACT_READ,  64'h100); // bit 8 is tag: dirty eviction
            send_access(ACT_READ,  64'h0);
            send_access(ACT_WRITE, 64'hFF);  // last set
         end
         if (p == 1) begin
            // cache smaller than one set: everything lands in set 0
            send_access(ACT_READ,  64'h0);
            send_access(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFF);
         end
         if (p == 2) holds_asked++;
         run_random(RANDOM_PER_PHASE, (p == 4) ? RANDOM_PER_PHASE / 2 : -1);
      end
      wait_drained();

      $display("Checked %0d lookups across %0d cache geometries.", sb.checked, PHASES + 1);
      $display("Of these %0d hit and %0d evicted a dirty line.", sb.hits, sb.dirty_evictions);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
